>>> src/u8dec_pkg.sv
// Shared types, constants and the byte classifier for the UTF-8 decoder.
// No dependencies; imported by the front, the back and the top level.
`default_nettype none

package u8dec_pkg;

  // Sequence length codes a lead byte calls for
  localparam logic [2:0] LEN_BAD = 3'd0;
  localparam logic [2:0] LEN_1   = 3'd1;
  localparam logic [2:0] LEN_2   = 3'd2;
  localparam logic [2:0] LEN_3   = 3'd3;
  localparam logic [2:0] LEN_4   = 3'd4;

  // Scalar value limits
  localparam int unsigned CP_W   = 21;
  localparam logic [CP_W-1:0] CP_MAX  = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI = 21'h00DFFF;
  localparam logic [CP_W-1:0] MIN_2   = 21'h000080;
  localparam logic [CP_W-1:0] MIN_3   = 21'h000800;
  localparam logic [CP_W-1:0] MIN_4   = 21'h010000;
  localparam logic [CP_W-1:0] BMP_MAX = 21'h00FFFF;
  localparam logic [CP_W-1:0] LINE_FEED = 21'h00000A;

  // Output field widths and packing
  localparam int unsigned WIDTH_W  = 3;
  localparam int unsigned FIELD_W  = 32;
  localparam int unsigned OUT_DATA_W = CP_W + WIDTH_W + 4 * FIELD_W;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // One source byte with its classification
  typedef struct packed {
    logic [7:0] data;
    logic [2:0] need;   // length code when used as a lead
    logic       cont;   // 10xxxxxx continuation byte
  } u8dec_byte_t;

  // One queued request
  typedef struct packed {
    u8dec_byte_t b;
    logic        src_end;
  } u8dec_item_t;

  // Queue head as seen by the back
  typedef struct packed {
    logic        valid;
    u8dec_item_t item;
  } u8dec_head_t;

  function automatic u8dec_byte_t classify(input logic [7:0] b);
    u8dec_byte_t r;
    r.data = b;
    r.cont = (b[7:6] == 2'b10);
    if (b[7] == 1'b0) begin
      r.need = LEN_1;
    end else if ((b & 8'hE0) == 8'hC0) begin
      r.need = LEN_2;
    end else if ((b & 8'hF0) == 8'hE0) begin
      r.need = LEN_3;
    end else if ((b & 8'hF8) == 8'hF0) begin
      r.need = LEN_4;
    end else begin
      r.need = LEN_BAD;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/u8dec_front.sv
// Input side of the UTF-8 decoder: classifies each byte and queues it.
// Depends on u8dec_pkg.
`default_nettype none

module u8dec_front
  import u8dec_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tlast,   // end_of_source
  input  wire logic        pop,
  output      u8dec_head_t head
);

  u8dec_item_t            queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0]      wr_ptr;
  logic [QPTR_W-1:0]      rd_ptr;
  logic [QCNT_W-1:0]      count;
  logic                   push;
  logic                   take;

  // Accept while there is room in the queue
  assign s_tready = (count != QCNT_W'(QUEUE_DEPTH));
  assign push     = s_tvalid && s_tready;
  assign take     = pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.item  = queue[rd_ptr];

  // Store the classified request
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= '{b: classify(s_tdata), src_end: s_tlast};
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (take) rd_ptr <= rd_ptr + 1'b1;
      if (push && !take) begin
        count <= count + 1'b1;
      end else if (take && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/u8dec_back.sv
// Decode side of the UTF-8 decoder: window of up to four bytes, sequence
// checks, position counters and the output register. Depends on u8dec_pkg.
`default_nettype none

module u8dec_back
  import u8dec_pkg::*;
#(
  parameter int unsigned POSITION_BITS = 32
)(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire u8dec_head_t           head,
  output      logic                  pop,
  output      logic                  m_tvalid,
  input  wire logic                  m_tready,
  output      logic [OUT_DATA_W-1:0] m_tdata,   // code_point, byte_width,
                                                // byte_offset, utf16_index,
                                                // line_number, column_number
  output      logic                  m_tuser,   // valid_res
  output      logic                  m_tlast    // last_of_run
);

  localparam int unsigned P = POSITION_BITS;

  // Byte window
  u8dec_byte_t       win      [4];
  u8dec_byte_t       win_next [4];
  logic [2:0]        n;
  logic              src_end;
  logic              active;

  // Position counters
  logic [P-1:0]      byte_pos;
  logic [P-1:0]      unit_pos;
  logic [P-1:0]      line;
  logic [P-1:0]      column;
  logic [FIELD_W-1:0] byte_pos32, unit_pos32, line32, column32;

  // Output register
  logic              out_valid;
  logic [CP_W-1:0]   out_cp;
  logic              out_ok;
  logic [WIDTH_W-1:0] out_width;
  logic [FIELD_W-1:0] out_offset, out_unit, out_line, out_column;
  logic              out_last;

  // Decode terms
  logic              can_emit, eval, stop, emit, fits, ok, more;
  logic              c2, c3, c4;
  logic [CP_W-1:0]   v2, v3, v4, value, emit_cp;
  logic [2:0]        need, used, n_rem;
  logic [1:0]        units;
  u8dec_byte_t       nxt;

  function automatic logic [P-1:0] sat_add(input logic [P-1:0] a,
                                           input logic [2:0] inc);
    logic [P:0] sum;
    sum = {1'b0, a} + (P+1)'(inc);
    return sum[P] ? {P{1'b1}} : sum[P-1:0];
  endfunction

  // Low 32 bits of the counters, zero-extended for narrow counters
  generate
    if (P >= FIELD_W) begin : g_wide
      assign byte_pos32 = byte_pos[FIELD_W-1:0];
      assign unit_pos32 = unit_pos[FIELD_W-1:0];
      assign line32     = line[FIELD_W-1:0];
      assign column32   = column[FIELD_W-1:0];
    end else begin : g_narrow
      assign byte_pos32 = {{(FIELD_W-P){1'b0}}, byte_pos};
      assign unit_pos32 = {{(FIELD_W-P){1'b0}}, unit_pos};
      assign line32     = {{(FIELD_W-P){1'b0}}, line};
      assign column32   = {{(FIELD_W-P){1'b0}}, column};
    end
  endgenerate

  // Decide the sequence at the window head
  always_comb begin
    can_emit = !out_valid || m_tready;
    eval     = active && can_emit;
    need     = win[0].need;
    fits     = (need <= n);
    stop     = (need >= LEN_2) && !fits && !src_end;

    c2 = win[1].cont;
    c3 = c2 && win[2].cont;
    c4 = c3 && win[3].cont;
    v2 = {10'd0, win[0].data[4:0], win[1].data[5:0]};
    v3 = {5'd0, win[0].data[3:0], win[1].data[5:0], win[2].data[5:0]};
    v4 = {win[0].data[2:0], win[1].data[5:0], win[2].data[5:0], win[3].data[5:0]};

    case (need)
      LEN_1: begin
        ok    = 1'b1;
        value = {13'd0, win[0].data};
      end
      LEN_2: begin
        ok    = fits && c2 && (v2 >= MIN_2);
        value = v2;
      end
      LEN_3: begin
        ok    = fits && c3 && (v3 >= MIN_3) && !((v3 >= SURR_LO) && (v3 <= SURR_HI));
        value = v3;
      end
      LEN_4: begin
        ok    = fits && c4 && (v4 >= MIN_4) && (v4 <= CP_MAX);
        value = v4;
      end
      default: begin
        ok    = 1'b0;
        value = {13'd0, win[0].data};
      end
    endcase

    used    = ok ? need : LEN_1;
    emit_cp = ok ? value : {13'd0, win[0].data};
    units   = (emit_cp > BMP_MAX) ? 2'd2 : 2'd1;
    n_rem   = n - used;
    emit    = eval && !stop;

    // Look ahead: does the rest of the window give another result now
    nxt  = win[used[1:0]];
    more = (n_rem != 3'd0) &&
           !((nxt.need >= LEN_2) && (nxt.need > n_rem) && !src_end);

    pop = !active;
  end

  // Shift out consumed bytes, append a popped byte
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      win_next[i] = win[i];
    end
    if (emit) begin
      for (int i = 0; i < 4; i++) begin
        if ((3'(i) + used) < 3'd4) begin
          win_next[i] = win[2'(3'(i) + used)];
        end
      end
    end else if (pop && head.valid) begin
      win_next[n[1:0]] = head.item.b;
    end
  end

  // Hold window bytes
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      win[i] <= win_next[i];
    end
  end

  // Sequence control and position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      n        <= 3'd0;
      src_end  <= 1'b0;
      active   <= 1'b0;
      byte_pos <= '0;
      unit_pos <= '0;
      line     <= P'(1);
      column   <= P'(1);
    end else if (pop && head.valid) begin
      n       <= n + 3'd1;
      src_end <= head.item.src_end;
      active  <= 1'b1;
    end else if (eval) begin
      if (stop) begin
        active <= 1'b0;
      end else begin
        n        <= n_rem;
        active   <= more;
        byte_pos <= sat_add(byte_pos, used);
        unit_pos <= sat_add(unit_pos, {1'b0, units});
        if (emit_cp == LINE_FEED) begin
          line   <= sat_add(line, 3'd1);
          column <= P'(1);
        end else begin
          column <= sat_add(column, {1'b0, units});
        end
      end
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_cp     <= emit_cp;
      out_ok     <= ok;
      out_width  <= used;
      out_offset <= byte_pos32;
      out_unit   <= unit_pos32;
      out_line   <= line32;
      out_column <= column32;
      out_last   <= !more;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_column, out_line, out_unit, out_offset, out_width, out_cp};
  assign m_tuser  = out_ok;
  assign m_tlast  = out_last;

endmodule

`default_nettype wire

>>> src/utf8_decoder_with_position.sv
// UTF-8 decoder with position tags, top level.
// Slave stream: tdata[7:0] is one source byte, tlast marks the final byte
// of the source; held bytes are then flushed as invalid leads.
// Master stream: one request per decoded sequence. tdata carries the code
// point, byte width, byte offset, UTF-16 index, line and column of the
// sequence start; tuser is 1 for a well-formed sequence; tlast marks the
// final result caused by one input byte. A byte that only completes part of
// a sequence causes no result.
// Flow: an accepted byte enters a four-entry queue; the decoder loads it
// from the queue head while idle and then emits its results one at a time,
// or holds the byte if it only starts or continues a sequence. Loading and
// decoding alternate: the decoder takes no new byte until the results of
// the last one are out.
// Reset clears the queue, the held bytes and the counters (offsets 0, line
// and column 1). When the receiver stalls, the result register holds, the
// decoder waits, and the queue keeps taking bytes until it is full.
// Position counters are POSITION_BITS wide and saturate; outputs show the
// low 32 bits. Depends on u8dec_pkg, u8dec_front and u8dec_back.
`default_nettype none

module utf8_decoder_with_position
  import u8dec_pkg::*;
#(
  parameter int unsigned POSITION_BITS = 32
)(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output      logic                  s_tready,
  input  wire logic [7:0]            s_tdata,   // [7:0] data_byte
  input  wire logic                  s_tlast,   // end_of_source
  output      logic                  m_tvalid,
  input  wire logic                  m_tready,
  output      logic [OUT_DATA_W-1:0] m_tdata,   // [20:0] code_point,
                                                // [23:21] byte_width,
                                                // [55:24] byte_offset,
                                                // [87:56] utf16_index,
                                                // [119:88] line_number,
                                                // [151:120] column_number
  output      logic                  m_tuser,   // valid_res
  output      logic                  m_tlast    // last_of_run
);

  u8dec_head_t head;
  logic        pop;

  u8dec_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .pop      (pop),
    .head     (head)
  );

  u8dec_back #(
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire
